FILE: hw/rtl/assert_macros.svh
// Concurrent assertion helpers; clocked on clk_i, disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ACPU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ACPU_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ACPU_ASSERT(lbl, prop, msg)
`define ACPU_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

FILE: hw/rtl/acpu_pkg.sv
`timescale 1ns / 1ps
package acpu_pkg;

  localparam int WORD_W    = 32;
  localparam int MEM_DEPTH = 64;
  localparam int MEM_AW    = 6;
  localparam int PC_W      = 8;
  localparam int OP_W      = 4;
  localparam int MODE_W    = 2;
  localparam int OPND_W    = 12;

  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 88;

  localparam logic [OP_W-1:0] OP_NOP  = 4'd0;
  localparam logic [OP_W-1:0] OP_CLA  = 4'd1;
  localparam logic [OP_W-1:0] OP_NEG  = 4'd2;
  localparam logic [OP_W-1:0] OP_LDA  = 4'd3;
  localparam logic [OP_W-1:0] OP_STA  = 4'd4;
  localparam logic [OP_W-1:0] OP_ADD  = 4'd5;
  localparam logic [OP_W-1:0] OP_SUB  = 4'd6;
  localparam logic [OP_W-1:0] OP_JMP  = 4'd7;
  localparam logic [OP_W-1:0] OP_JMZ  = 4'd8;
  localparam logic [OP_W-1:0] OP_JMN  = 4'd9;
  localparam logic [OP_W-1:0] OP_JMV  = 4'd10;
  localparam logic [OP_W-1:0] OP_HALT = 4'd11;

  localparam logic [MODE_W-1:0] MODE_DIR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_IMM = 2'd1;
  localparam logic [MODE_W-1:0] MODE_IND = 2'd2;
  localparam logic [MODE_W-1:0] MODE_REL = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [MODE_W-1:0] mode;
    logic [OPND_W-1:0] opnd;
  } instr_t;

  typedef struct packed {
    logic [WORD_W-1:0] acc;
    logic [MEM_AW-1:0] mar;
    logic [WORD_W-1:0] mdr;
    logic [PC_W-1:0]   pc;
    logic              ovf;
  } arch_t;

  typedef struct packed {
    logic              we;
    logic [MEM_AW-1:0] addr;
    logic [WORD_W-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic ovf;
    logic halt;
  } status_t;

endpackage

FILE: hw/rtl/accumulator_cpu_execute.sv
`timescale 1ns / 1ps
// Execute unit of a small accumulator machine. Each transfer on the slave side is one
// instruction; each produces exactly one result transfer with the new PC, AC, MAR, MDR,
// flags and a halt mark. The 64-word data memory is a single synchronous RAM with a
// registered read port. An instruction passes through accept, operand read, and execute
// and write-back; indirect LDA, ADD, SUB and STA chase a pointer through a second
// dependent RAM read before execute. A new instruction is accepted only after the last
// one has left the execute stage. A result that is not taken holds the next instruction
// in the execute stage. The memory reads as zero after reset through one valid bit per
// word, so no clearing pass is needed and the block is ready right after reset.
module accumulator_cpu_execute (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // req_type[3:0], addr_mode[5:4], operand[17:6], zero fill
  input  logic [acpu_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // next_pc[7:0], acc_value[39:8], addr_reg[45:40], data_reg[77:46], zero_flag[78],
  // negative_flag[79], overflow_flag[80], halted[81], zero fill
  output logic [acpu_pkg::M_TDATA_W-1:0] m_axis_tdata_o
);
  import acpu_pkg::*;

  `include "assert_macros.svh"

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD1  = 2'd1;
  localparam logic [1:0] ST_RD2  = 2'd2;
  localparam logic [1:0] ST_EXE  = 2'd3;

  logic [1:0]           state_q, state_d;
  instr_t               in_ins;
  instr_t               ins_q;
  logic [MEM_AW-1:0]    addr_q, addr_d;
  logic [MEM_AW-1:0]    first_addr;
  logic [MEM_AW-1:0]    rd_addr;
  logic [WORD_W-1:0]    word_q, word_d;
  logic [WORD_W-1:0]    ram_rdata;
  logic [WORD_W-1:0]    rd_word;
  logic [MEM_DEPTH-1:0] vld_q;
  logic                 rd_vld_q;
  arch_t                arch_q, arch_d;
  mem_wr_t              wr;
  status_t              stat;
  logic                 accept;
  logic                 commit;
  logic                 ind2;
  logic                 m_tvalid_q;
  logic [M_TDATA_W-1:0] m_tdata_q;
  logic [M_TDATA_W-1:0] res;

  assign in_ins.op   = s_axis_tdata_i[3:0];
  assign in_ins.mode = s_axis_tdata_i[5:4];
  assign in_ins.opnd = s_axis_tdata_i[17:6];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign commit          = (state_q == ST_EXE) && (!m_tvalid_q || m_axis_tready_i);

  assign first_addr = (in_ins.mode == MODE_REL) ? (arch_q.mar + in_ins.opnd[MEM_AW-1:0])
                                                : in_ins.opnd[MEM_AW-1:0];
  assign ind2 = (ins_q.mode == MODE_IND) &&
                (ins_q.op == OP_LDA || ins_q.op == OP_ADD ||
                 ins_q.op == OP_SUB || ins_q.op == OP_STA);
  assign rd_word = rd_vld_q ? ram_rdata : '0;
  assign rd_addr = (state_q == ST_RD1) ? rd_word[MEM_AW-1:0] : first_addr;

  acpu_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MEM_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (commit && wr.we),
    .waddr_i(wr.addr),
    .wdata_i(wr.data),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  acpu_alu u_alu (
    .ins_i (ins_q),
    .addr_i(addr_q),
    .word_i(word_q),
    .arch_i(arch_q),
    .arch_o(arch_d),
    .wr_o  (wr),
    .stat_o(stat)
  );

  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    word_d  = word_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          addr_d  = first_addr;
          state_d = ST_RD1;
        end
      end
      ST_RD1: begin
        word_d = rd_word;
        if (ind2) begin
          addr_d  = rd_word[MEM_AW-1:0];
          state_d = ST_RD2;
        end else begin
          state_d = ST_EXE;
        end
      end
      ST_RD2: begin
        word_d  = rd_word;
        state_d = ST_EXE;
      end
      ST_EXE: begin
        if (commit) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign res = {6'd0, stat.halt, stat.ovf, arch_d.acc[WORD_W-1], (arch_d.acc == '0),
                arch_d.mdr, arch_d.mar, arch_d.acc, arch_d.pc};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      arch_q     <= '0;
      vld_q      <= '0;
      rd_vld_q   <= 1'b0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= vld_q[rd_addr];
      if (commit) begin
        arch_q <= arch_d;
        if (wr.we) begin
          vld_q[wr.addr] <= 1'b1;
        end
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    word_q <= word_d;
    if (accept) begin
      ins_q <= in_ins;
    end
    if (commit) begin
      m_tdata_q <= res;
    end
  end

  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = m_tdata_q;

  `ACPU_ASSERT(a_accept_reads, accept |=> state_q == ST_RD1, "accept did not start a read")
  `ACPU_ASSERT(a_result_from_exe, $rose(m_tvalid_q) |-> $past(state_q) == ST_EXE,
               "result appeared without execute")
  `ACPU_ASSERT_NEVER(a_wr_outside_exe, wr.we && commit && state_q != ST_EXE,
                     "memory written outside execute")

endmodule

FILE: hw/rtl/acpu_ram.sv
`timescale 1ns / 1ps
module acpu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/acpu_alu.sv
`timescale 1ns / 1ps
module acpu_alu (
  input  acpu_pkg::instr_t               ins_i,
  input  logic [acpu_pkg::MEM_AW-1:0]    addr_i,
  input  logic [acpu_pkg::WORD_W-1:0]    word_i,
  input  acpu_pkg::arch_t                arch_i,
  output acpu_pkg::arch_t                arch_o,
  output acpu_pkg::mem_wr_t              wr_o,
  output acpu_pkg::status_t              stat_o
);
  import acpu_pkg::*;

  logic [WORD_W-1:0] a;
  logic [WORD_W-1:0] imm;
  logic [WORD_W-1:0] val;
  logic [WORD_W-1:0] sum;
  logic [WORD_W-1:0] dif;
  logic [WORD_W-1:0] neg;
  logic              ovf_add;
  logic              ovf_sub;
  logic              take;
  logic [PC_W-1:0]   pc_inc;

  assign a       = arch_i.acc;
  assign imm     = {{(WORD_W-OPND_W){ins_i.opnd[OPND_W-1]}}, ins_i.opnd};
  assign val     = (ins_i.mode == MODE_IMM) ? imm : word_i;
  assign sum     = a + val;
  assign dif     = a - val;
  assign neg     = '0 - a;
  assign ovf_add = (~(a[WORD_W-1] ^ val[WORD_W-1])) & (a[WORD_W-1] ^ sum[WORD_W-1]);
  assign ovf_sub = (a[WORD_W-1] ^ val[WORD_W-1]) & (a[WORD_W-1] ^ dif[WORD_W-1]);
  assign pc_inc  = arch_i.pc + PC_W'(1);

  always_comb begin
    case (ins_i.op)
      OP_JMP:  take = 1'b1;
      OP_JMZ:  take = (a == '0);
      OP_JMN:  take = a[WORD_W-1];
      OP_JMV:  take = arch_i.ovf;
      default: take = 1'b0;
    endcase
  end

  always_comb begin
    arch_o      = arch_i;
    arch_o.pc   = pc_inc;
    wr_o.we     = 1'b0;
    wr_o.addr   = addr_i;
    wr_o.data   = a;
    stat_o.ovf  = 1'b0;
    stat_o.halt = 1'b0;
    case (ins_i.op)
      OP_CLA: begin
        arch_o.acc = '0;
      end
      OP_NEG: begin
        stat_o.ovf = a[WORD_W-1] & ~(|a[WORD_W-2:0]);
        arch_o.acc = neg;
        arch_o.ovf = stat_o.ovf;
      end
      OP_LDA, OP_ADD, OP_SUB: begin
        if (ins_i.mode != MODE_IMM) begin
          arch_o.mar = addr_i;
          arch_o.mdr = word_i;
        end
        if (ins_i.op == OP_LDA) begin
          arch_o.acc = val;
        end else if (ins_i.op == OP_ADD) begin
          arch_o.acc = sum;
          stat_o.ovf = ovf_add;
          arch_o.ovf = ovf_add;
        end else begin
          arch_o.acc = dif;
          stat_o.ovf = ovf_sub;
          arch_o.ovf = ovf_sub;
        end
      end
      OP_STA: begin
        wr_o.we = 1'b1;
        if (ins_i.mode != MODE_IMM) begin
          arch_o.mar = addr_i;
          arch_o.mdr = a;
        end
      end
      OP_JMP, OP_JMZ, OP_JMN, OP_JMV: begin
        if (take) begin
          case (ins_i.mode)
            MODE_DIR: arch_o.pc = ins_i.opnd[PC_W-1:0];
            MODE_IND: begin
              arch_o.mar = addr_i;
              arch_o.mdr = word_i;
              arch_o.pc  = word_i[PC_W-1:0];
            end
            MODE_REL: arch_o.pc = arch_i.pc + ins_i.opnd[PC_W-1:0];
            default:  arch_o.pc = pc_inc;
          endcase
        end
      end
      OP_HALT: begin
        arch_o.pc   = arch_i.pc;
        stat_o.halt = 1'b1;
      end
      default: begin
        arch_o.pc = pc_inc;
      end
    endcase
  end

endmodule
